// ===== hw/rtl/lfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfs_pkg - shared types and constants of the line field splitter
// Configuration codes, the job descriptor passed from front to back, and the
// release notice that hands a line buffer bank back to the front.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  // Widths of job fields, sized for the largest supported line length (64)
  localparam int unsigned JOB_IDX_W = 6;
  localparam int unsigned JOB_LEN_W = 7;

  // Configuration register indexes
  localparam logic [1:0] CFG_TAKE_LAST = 2'd0;
  localparam logic [1:0] CFG_SEP_ONE   = 2'd1;
  localparam logic [1:0] CFG_SEP_TWO   = 2'd2;

  localparam logic [7:0] SEP_ONE_RESET = 8'd59;
  localparam logic [7:0] SEP_TWO_RESET = 8'd58;

  typedef struct packed {
    logic       take_last;
    logic [7:0] sep_one;
    logic [7:0] sep_two;
  } cfg_t;

  // One emitted part: buffer bank, first byte index, exclusive stop index
  typedef struct packed {
    logic                 bank;
    logic [JOB_IDX_W-1:0] first;
    logic [JOB_LEN_W-1:0] stop;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

// ===== hw/rtl/line_field_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// line_field_splitter_unit - emits one field of each separated line
// Buffers lines of a byte stream and, at each newline, emits the text before
// or after the last separator, closed by a newline, or drops the line.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------
//  input   | in_valid_i / in_ready_o   | data_byte_i
//  output  | out_valid_o / out_ready_i | out_byte_o, last_of_run_o
//  config  | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// Input bytes are taken one per cycle while the current line buffer bank is
// free. Two banks let one line fill while the previous one is emitted.
// Each emitted byte is read from the buffer, then output; the closing newline
// is output directly. Input stalls only when both banks hold lines not yet
// fully emitted. No clearing pass after reset; the block is ready at once.
// ----------------------------------------------------------------------------
module line_field_splitter_unit import lfs_pkg::*; #(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  localparam int unsigned IdxW = $clog2(LINE_MAX);
  localparam int unsigned LenW = $clog2(LINE_MAX + 1);

  cfg_t          cfg_q;
  logic          mem_we;
  logic [IdxW:0] mem_addr;
  logic [7:0]    mem_data;
  logic          push;
  job_t          push_job;
  logic          pop;
  logic          job_valid;
  job_t          pop_job;
  logic          q_full;
  release_t      rel;
  logic [1:0]    busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.take_last <= 1'b0;
      cfg_q.sep_one   <= SEP_ONE_RESET;
      cfg_q.sep_two   <= SEP_TWO_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TAKE_LAST: cfg_q.take_last <= cfg_data_i[0];
        CFG_SEP_ONE:   cfg_q.sep_one   <= cfg_data_i;
        CFG_SEP_TWO:   cfg_q.sep_two   <= cfg_data_i;
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  lfs_front #(
    .LINE_MAX (LINE_MAX),
    .IDX_W    (IdxW),
    .LEN_W    (LenW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_data_o  (mem_data),
    .push_o      (push),
    .job_o       (push_job),
    .rel_i       (rel),
    .busy_o      (busy)
  );

  lfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (pop_job),
    .full_o  (q_full)
  );

  lfs_back #(
    .LINE_MAX (LINE_MAX),
    .IDX_W    (IdxW),
    .LEN_W    (LenW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mem_we_i      (mem_we),
    .mem_addr_i    (mem_addr),
    .mem_data_i    (mem_data),
    .job_valid_i   (job_valid),
    .job_i         (pop_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .rel_o         (rel)
  );

  // closing transaction of a part always carries a newline
  a_last_is_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_run_o |-> out_byte_o == NEWLINE_BYTE)
    else $error("closing byte is not a newline");

  // job queue never overflows
  a_no_queue_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job pushed into full queue");

  // a bank is released only while it is owned
  a_release_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel.valid |-> busy[rel.bank])
    else $error("release of a bank that is not busy");

  // a queued job always points at an owned bank
  a_job_bank_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> busy[pop_job.bank])
    else $error("queued job refers to a free bank");

endmodule

// ===== hw/rtl/lfs_front.sv =====
// ----------------------------------------------------------------------------
// lfs_front - byte intake and line classification
// Writes each byte of a line into the free buffer bank, tracks the last
// separator and, at the newline, either drops the line or queues a job.
// ----------------------------------------------------------------------------
module lfs_front import lfs_pkg::*; #(
  parameter int unsigned LINE_MAX = 64,
  parameter int unsigned IDX_W    = $clog2(LINE_MAX),
  parameter int unsigned LEN_W    = $clog2(LINE_MAX + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  // line buffer write port
  output logic             mem_we_o,
  output logic [IDX_W:0]   mem_addr_o,
  output logic [7:0]       mem_data_o,
  // job queue push
  output logic             push_o,
  output job_t             job_o,
  // bank release from the back end
  input  release_t         rel_i,
  output logic [1:0]       busy_o
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(LINE_MAX);

  logic [LEN_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] sep_idx_q, sep_idx_d;
  logic             seen_q, seen_d;
  logic             ovf_q, ovf_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;

  logic             accept;
  logic             is_nl;
  logic             is_sep;
  logic             drop;
  logic [LEN_W-1:0] sep_ext;

  assign in_ready_o = ~busy_q[bank_q];
  assign accept     = in_valid_i & in_ready_o;
  assign is_nl      = (data_byte_i == NEWLINE_BYTE);
  assign is_sep     = (data_byte_i == cfg_i.sep_one) | (data_byte_i == cfg_i.sep_two);
  assign sep_ext    = LEN_W'(sep_idx_q);
  assign drop       = ovf_q | ~seen_q | (sep_idx_q == '0) | ((sep_ext + 1'b1) >= len_q);

  // buffer write for a stored byte
  assign mem_we_o   = accept & ~is_nl & ~ovf_q & (len_q < MaxLen);
  assign mem_addr_o = {bank_q, len_q[IDX_W-1:0]};
  assign mem_data_o = data_byte_i;

  // job descriptor for the line that just closed
  assign push_o = accept & is_nl & ~drop;
  always_comb begin
    job_o.bank = bank_q;
    if (cfg_i.take_last) begin
      job_o.first = JOB_IDX_W'(sep_ext + 1'b1);
      job_o.stop  = JOB_LEN_W'(len_q);
    end else begin
      job_o.first = '0;
      job_o.stop  = JOB_LEN_W'(sep_idx_q);
    end
  end

  // line state update
  always_comb begin
    len_d     = len_q;
    sep_idx_d = sep_idx_q;
    seen_d    = seen_q;
    ovf_d     = ovf_q;
    bank_d    = bank_q;
    if (accept) begin
      if (is_nl) begin
        len_d     = '0;
        sep_idx_d = '0;
        seen_d    = 1'b0;
        ovf_d     = 1'b0;
        if (!drop) begin
          bank_d = ~bank_q;
        end
      end else if (!ovf_q) begin
        if (len_q >= MaxLen) begin
          ovf_d = 1'b1;
        end else begin
          if (is_sep) begin
            sep_idx_d = len_q[IDX_W-1:0];
            seen_d    = 1'b1;
          end
          len_d = len_q + 1'b1;
        end
      end
    end
  end

  // bank ownership: set when queued, cleared when the back end is done
  always_comb begin
    busy_d = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (push_o) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      sep_idx_q <= '0;
      seen_q    <= 1'b0;
      ovf_q     <= 1'b0;
      bank_q    <= 1'b0;
      busy_q    <= '0;
    end else begin
      len_q     <= len_d;
      sep_idx_q <= sep_idx_d;
      seen_q    <= seen_d;
      ovf_q     <= ovf_d;
      bank_q    <= bank_d;
      busy_q    <= busy_d;
    end
  end

endmodule

// ===== hw/rtl/lfs_queue.sv =====
// ----------------------------------------------------------------------------
// lfs_queue - two-entry job queue between front and back
// Holds descriptors of lines waiting to be emitted.
// ----------------------------------------------------------------------------
module lfs_queue import lfs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o,
  output logic full_o
);

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign job_o   = slot_q[rd_ptr_q];

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lfs_back.sv =====
// ----------------------------------------------------------------------------
// lfs_back - line buffer and part emitter
// Two-bank line buffer; reads the selected part of a queued line byte by
// byte and closes it with a newline, then releases the bank.
// ----------------------------------------------------------------------------
module lfs_back import lfs_pkg::*; #(
  parameter int unsigned LINE_MAX = 64,
  parameter int unsigned IDX_W    = $clog2(LINE_MAX),
  parameter int unsigned LEN_W    = $clog2(LINE_MAX + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // buffer write port
  input  logic           mem_we_i,
  input  logic [IDX_W:0] mem_addr_i,
  input  logic [7:0]     mem_data_i,
  // job queue
  input  logic           job_valid_i,
  input  job_t           job_i,
  output logic           pop_o,
  // result channel
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_of_run_o,
  output release_t       rel_o
);

  localparam int unsigned MemDepth = 2 ** (IDX_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_SHOW = 4'b0100,
    ST_NL   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [LEN_W-1:0] stop_q, stop_d;
  logic             bank_q, bank_d;
  logic [7:0]       mem_q [MemDepth];
  logic [7:0]       rd_data_q;
  logic [LEN_W-1:0] ptr_next;

  // line buffer
  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem_q[mem_addr_i] <= mem_data_i;
    end
    if (state_q == ST_READ) begin
      rd_data_q <= mem_q[{bank_q, ptr_q}];
    end
  end

  assign ptr_next = LEN_W'(ptr_q) + 1'b1;

  // emit sequencer
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    stop_d    = stop_q;
    bank_d    = bank_q;
    pop_o     = 1'b0;
    rel_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          ptr_d   = IDX_W'(job_i.first);
          stop_d  = LEN_W'(job_i.stop);
          bank_d  = job_i.bank;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready_i) begin
          if (ptr_next == stop_q) begin
            state_d = ST_NL;
          end else begin
            ptr_d   = ptr_next[IDX_W-1:0];
            state_d = ST_READ;
          end
        end
      end
      ST_NL: begin
        if (out_ready_i) begin
          rel_o.valid = 1'b1;
          rel_o.bank  = bank_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o   = (state_q == ST_SHOW) | (state_q == ST_NL);
  assign out_byte_o    = (state_q == ST_NL) ? NEWLINE_BYTE : rd_data_q;
  assign last_of_run_o = (state_q == ST_NL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    stop_q <= stop_d;
    bank_q <= bank_d;
  end

endmodule

// ===== verif/line_field_splitter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// line_field_splitter_unit_tb - self-checking bench for the line field splitter
// Streams lines of bytes into the block under several separator settings,
// predicts the emitted field of every line, and checks each output
// transaction in order. The sender and receiver stall at random, and one
// long receiver hold-off backs the block up until its input stalls.
// ----------------------------------------------------------------------------
module line_field_splitter_unit_tb;
  import lfs_pkg::*;

  localparam int unsigned LINE_MAX    = 64;
  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [1:0]  CFG_UNUSED  = 2'd3;  // index past the register list

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } field_byte_t;

  // DUT signals
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  // Stimulus and expected output
  logic [7:0]  stream_q[$];
  field_byte_t field_bytes_q[$];
  int          errors = 0;
  logic        in_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_start = 1'b0;
  logic        hold_used = 1'b0;
  int          hold_left = 0;

  // Shadow configuration and line state
  logic       take_last = 1'b0;
  logic [7:0] sep_one = SEP_ONE_RESET;
  logic [7:0] sep_two = SEP_TWO_RESET;
  logic [7:0] line_buf [LINE_MAX];
  logic [6:0] line_len = '0;
  logic [5:0] sep_idx = '0;
  logic       sep_seen = 1'b0;
  logic       line_over = 1'b0;

  line_field_splitter_unit #(.LINE_MAX(LINE_MAX)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Buffer one stream byte; on newline queue the selected field plus newline
  task automatic split_line_byte(input logic [7:0] b);
    int unsigned start_pos;
    int unsigned stop_pos;
    if (b != NEWLINE_BYTE) begin
      if (line_over) return;
      if (line_len >= LINE_MAX) begin
        line_over = 1'b1;
        return;
      end
      line_buf[line_len[5:0]] = b;
      if (b == sep_one || b == sep_two) begin
        sep_idx  = line_len[5:0];
        sep_seen = 1'b1;
      end
      line_len = line_len + 7'd1;
      return;
    end
    // dropped: overflow, no separator, separator first or last
    if (!(line_over || !sep_seen || sep_idx == 0 || sep_idx + 1 >= line_len)) begin
      if (take_last) begin
        start_pos = sep_idx + 1;
        stop_pos  = line_len;
      end else begin
        start_pos = 0;
        stop_pos  = sep_idx;
      end
      for (int unsigned i = start_pos; i < stop_pos; i++)
        field_bytes_q.push_back('{line_buf[i], 1'b0});
      field_bytes_q.push_back('{NEWLINE_BYTE, 1'b1});
    end
    line_len  = '0;
    sep_idx   = '0;
    sep_seen  = 1'b0;
    line_over = 1'b0;
  endtask

  // Input driver: next byte offered at the falling edge
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i  <= 1'b1;
        data_byte_i <= stream_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_start && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check output transactions, predict on input transactions
  always @(posedge clk_i) begin
    field_byte_t want;
    in_taken = in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (field_bytes_q.size() == 0) begin
        $error("unexpected output: out_byte %0d last_of_run %0b", out_byte_o, last_of_run_o);
        errors++;
      end else begin
        want = field_bytes_q.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %0d, got %0d", want.out_byte, out_byte_o);
          errors++;
        end
        if (last_of_run_o !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run, last_of_run_o);
          errors++;
        end
      end
    end
    if (rst_ni && in_taken) split_line_byte(data_byte_i);
  end

  // Register write, only while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_TAKE_LAST: take_last = val[0];
      CFG_SEP_ONE:   sep_one = val;
      CFG_SEP_TWO:   sep_two = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic tl, input logic [7:0] s1, input logic [7:0] s2);
    // upper bits of the one-bit register carry junk
    write_reg(CFG_TAKE_LAST, (8'($urandom) & 8'hfe) | {7'd0, tl});
    write_reg(CFG_SEP_ONE, s1);
    write_reg(CFG_SEP_TWO, s2);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
    stream_q.push_back(NEWLINE_BYTE);
  endtask

  // Line of given length, separator at sep_pos, other bytes lowercase letters
  task automatic push_long(input int len, input int sep_pos);
    for (int i = 0; i < len; i++)
      stream_q.push_back(i == sep_pos ? sep_one : 8'($urandom_range(122, 97)));
    stream_q.push_back(NEWLINE_BYTE);
  endtask

  // Random lines, mostly short and mostly holding a separator somewhere
  task automatic gen_lines(input int budget);
    int         n;
    int         len;
    logic [7:0] b;
    n = 0;
    while (n < budget) begin
      len = ($urandom_range(11) == 0) ? $urandom_range(70, 60) : $urandom_range(10);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 18) begin
          b = $urandom_range(1) ? sep_one : sep_two;
        end else begin
          b = 8'($urandom_range(255));
          if (b == NEWLINE_BYTE) b = 8'hf5;
        end
        stream_q.push_back(b);
      end
      stream_q.push_back(NEWLINE_BYTE);
      n += len + 1;
    end
  endtask

  // Wait until the stream is taken and every field byte has come out
  task automatic wait_drained();
    int guard;
    guard = 0;
    while (stream_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (field_bytes_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    // a dropped line may still be in flight
    repeat (200) @(posedge clk_i);
  endtask

  // Main sequence
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed lines under reset settings
    send_idle_pct = 33;
    recv_idle_pct = 69;
    push_text("a;b");
    push_text(";ab");
    push_text("ab:");
    push_text("");
    push_text("xy");
    stream_q.push_back(8'h00);
    stream_q.push_back(SEP_TWO_RESET);
    stream_q.push_back(8'hff);
    stream_q.push_back(NEWLINE_BYTE);
    push_text("p;q:r");
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_idle_pct = 33;
        recv_idle_pct = 69;
      end else if (p < 4) begin
        send_idle_pct = 69;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: configure(1'b1, SEP_ONE_RESET, SEP_TWO_RESET);
        1: configure(1'b0, 8'h00, 8'hff);
        2: configure(1'b1, NEWLINE_BYTE, 8'h2c);     // newline cannot separate
        3: begin
          configure(1'b0, 8'h7f, 8'h7f);             // both separators equal
          write_reg(CFG_UNUSED, 8'hff);
        end
        4: configure(1'b1, 8'hff, 8'h00);
        default: configure(1'b0, SEP_ONE_RESET, SEP_TWO_RESET);
      endcase
      if (p == 2) begin
        hold_start = 1'b1;
        // kept lines that occupy both banks, then one more to stall the input
        push_text("a,b");
        push_text("a,b");
        push_text("a,b");
      end
      if (p == 4) begin
        push_long(LINE_MAX, 30);       // full buffer, kept
        push_long(LINE_MAX, LINE_MAX - 1);  // separator last, dropped
        push_long(LINE_MAX + 2, 10);   // overflow, dropped
      end
      gen_lines(4);
      wait_drained();
    end

    if (field_bytes_q.size() != 0) begin
      $error("%0d expected output bytes never arrived", field_bytes_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * 200000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
